@@ rtl/fsd_pkg.sv @@
// Shared types, result codes and clock-try tables for the flux stream decoder.
package fsd_pkg;

   // Result kind codes
   localparam logic [2:0] RK_FLUX   = 3'd0;
   localparam logic [2:0] RK_REV    = 3'd1;
   localparam logic [2:0] RK_TRACK  = 3'd2;
   localparam logic [2:0] RK_FOUND  = 3'd3;
   localparam logic [2:0] RK_FAILED = 3'd4;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RPM_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RPM_HIGH = 2'd1;

   localparam int unsigned RPM_BITS  = 10;
   localparam int unsigned TICK_BITS = 6;
   localparam int unsigned FLUX_BITS = 38;
   localparam int unsigned CAND_BITS = 33;

   localparam logic [RPM_BITS-1:0] RPM_LOW_RESET  = 10'd285;
   localparam logic [RPM_BITS-1:0] RPM_HIGH_RESET = 10'd380;

   localparam logic [7:0] BYTE_CARRY = 8'h7f;

   // Index of the last sample clock tried, in order 25, 50, 100 MHz
   localparam logic [1:0] TRY_LAST = 2'd2;

   typedef enum logic [1:0] {
      OUT_FLUX,
      OUT_REV,
      OUT_TRACK,
      OUT_CLOCK
   } out_sel_type;

   typedef struct packed {
      logic        take;        // req ready
      logic        meas_add;    // add byte to measure count
      logic        flux_add;    // add byte to flux count
      logic        flux_clear;  // clear flux count
      logic        mul;         // form the limit products
      logic [1:0]  try_sel;     // clock under test
      logic        det_set;     // record detection result
      logic        meas_finish; // commit tick, clear measure state
      logic        out_load;    // load result register
      out_sel_type out_sel;
      logic        out_last;
   } fsd_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_kind;
      logic req_b7;
      logic req_last;
      logic item_b7;
      logic item_carry;
      logic item_last;
      logic tick_known;
      logic try_hit;
      logic out_free;
   } fsd_status_type;

   // 60e6 times the sample clock in MHz for each try
   function automatic logic [CAND_BITS-1:0] try_cand(logic [1:0] sel);
      logic [CAND_BITS-1:0] c;
      case (sel)
         2'd0:    c = 33'd1_500_000_000;
         2'd1:    c = 33'd3_000_000_000;
         default: c = 33'd6_000_000_000;
      endcase
      return c;
   endfunction

   // Tick period in ns for each try
   function automatic logic [TICK_BITS-1:0] try_tick(logic [1:0] sel);
      logic [TICK_BITS-1:0] t;
      case (sel)
         2'd0:    t = 6'd40;
         2'd1:    t = 6'd20;
         default: t = 6'd10;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/fsd_if.sv @@
// Valid/ready channel interfaces for byte input, results and register writes.
interface fsd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       track_last;

   modport source (output valid, output kind, output data_byte, output track_last,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input track_last,
                 output ready);
endinterface

interface fsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [37:0] flux_ns;
   logic [5:0]  tick_period;
   logic        last_of_run;

   modport source (output valid, output result_kind, output flux_ns,
                   output tick_period, output last_of_run, input ready);
   modport sink (input valid, input result_kind, input flux_ns,
                 input tick_period, input last_of_run, output ready);
endinterface

interface fsd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/fsd_datapath.sv @@
// Counters, limit products, clock compare and result register of the decoder.
module fsd_datapath
   import fsd_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   fsd_req_if.sink        req_bus,
   fsd_rsp_if.source      rsp_bus,
   fsd_csr_if.sink        csr_bus,
   input  fsd_cmd_type    cmd,
   output fsd_status_type status
);

   localparam int unsigned PROD_BITS = COUNT_BITS + RPM_BITS + 1;
   localparam int unsigned CMP_BITS  = (PROD_BITS > CAND_BITS) ? PROD_BITS : CAND_BITS;
   localparam int unsigned FPROD_BITS = COUNT_BITS + TICK_BITS;
   localparam int unsigned FW = (FPROD_BITS > FLUX_BITS) ? FPROD_BITS : FLUX_BITS;

   logic [RPM_BITS-1:0]   rpm_low_ff, rpm_low_in;
   logic [RPM_BITS-1:0]   rpm_high_ff, rpm_high_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [TICK_BITS-1:0]  det_tick_ff, det_tick_in;
   logic [COUNT_BITS-1:0] meas_ff, meas_in;
   logic                  closed_ff, closed_in;
   logic [COUNT_BITS-1:0] flux_ff, flux_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  item_b7_ff, item_b7_in;
   logic                  item_carry_ff, item_carry_in;
   logic                  item_last_ff, item_last_in;
   logic [PROD_BITS-1:0]  prod_lo_ff, prod_lo_in;
   logic [PROD_BITS-1:0]  prod_hi_ff, prod_hi_in;
   logic [2:0]            rsp_kind_ff, rsp_kind_in;
   logic [FLUX_BITS-1:0]  rsp_flux_ff, rsp_flux_in;
   logic [TICK_BITS-1:0]  rsp_tick_ff, rsp_tick_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic [COUNT_BITS:0]   meas_sum;
   logic [COUNT_BITS:0]   flux_sum;
   logic [CMP_BITS-1:0]   cand;
   logic                  hit;
   logic [FW-1:0]         fprod;

   assign accept   = req_bus.valid && cmd.take;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = cmd.take;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_kind = rsp_kind_ff;
   assign rsp_bus.flux_ns     = rsp_flux_ff;
   assign rsp_bus.tick_period = rsp_tick_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   // Saturating sums of the incoming byte
   assign meas_sum = {1'b0, meas_ff} + {{(COUNT_BITS - 6){1'b0}}, req_bus.data_byte[6:0]};
   assign flux_sum = {1'b0, flux_ff} + {{(COUNT_BITS - 7){1'b0}}, req_bus.data_byte};

   // Test the selected clock against the speed limits
   assign cand = CMP_BITS'(try_cand(cmd.try_sel));
   assign hit  = (cand >= CMP_BITS'(prod_lo_ff)) && (cand < CMP_BITS'(prod_hi_ff));

   // Interval in ns, kept to the result width
   assign fprod = FW'(flux_ff) * FW'(tick_ff);

   always_comb begin
      status.req_valid  = req_bus.valid;
      status.req_kind   = req_bus.kind;
      status.req_b7     = req_bus.data_byte[7];
      status.req_last   = req_bus.track_last;
      status.item_b7    = item_b7_ff;
      status.item_carry = item_carry_ff;
      status.item_last  = item_last_ff;
      status.tick_known = (tick_ff != '0);
      status.try_hit    = hit;
      status.out_free   = out_free;
   end

   // Next state of control registers
   always_comb begin
      rpm_low_in  = rpm_low_ff;
      rpm_high_in = rpm_high_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RPM_LOW:  rpm_low_in  = csr_bus.data;
            CSR_RPM_HIGH: rpm_high_in = csr_bus.data;
            default: ;
         endcase
      end

      meas_in   = meas_ff;
      closed_in = closed_ff;
      if (accept && cmd.meas_add && !closed_ff) begin
         meas_in = meas_sum[COUNT_BITS] ? '1 : meas_sum[COUNT_BITS-1:0];
         if (req_bus.data_byte[7]) begin
            closed_in = 1'b1;
         end
      end

      tick_in = tick_ff;
      if (cmd.meas_finish) begin
         tick_in   = det_tick_ff;
         meas_in   = '0;
         closed_in = 1'b0;
      end

      det_tick_in = det_tick_ff;
      if (cmd.det_set) begin
         det_tick_in = hit ? try_tick(cmd.try_sel) : '0;
      end

      flux_in = flux_ff;
      if (accept && cmd.flux_add) begin
         flux_in = flux_sum[COUNT_BITS] ? '1 : flux_sum[COUNT_BITS-1:0];
      end else if (cmd.flux_clear) begin
         flux_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Next state of payload registers
   always_comb begin
      item_b7_in    = item_b7_ff;
      item_carry_in = item_carry_ff;
      item_last_in  = item_last_ff;
      if (accept) begin
         item_b7_in    = req_bus.data_byte[7];
         item_carry_in = (req_bus.data_byte == BYTE_CARRY);
         item_last_in  = req_bus.track_last;
      end

      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      if (cmd.mul) begin
         prod_lo_in = PROD_BITS'(rpm_low_ff) * PROD_BITS'(meas_ff);
         prod_hi_in = (PROD_BITS'(rpm_high_ff) + PROD_BITS'(1)) * PROD_BITS'(meas_ff);
      end

      rsp_kind_in = rsp_kind_ff;
      rsp_flux_in = rsp_flux_ff;
      rsp_tick_in = rsp_tick_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_flux_in = '0;
         rsp_tick_in = '0;
         rsp_last_in = cmd.out_last;
         case (cmd.out_sel)
            OUT_FLUX: begin
               rsp_kind_in = RK_FLUX;
               rsp_flux_in = fprod[FLUX_BITS-1:0];
            end
            OUT_REV: begin
               rsp_kind_in = RK_REV;
            end
            OUT_TRACK: begin
               rsp_kind_in = RK_TRACK;
            end
            default: begin
               rsp_kind_in = (det_tick_ff != '0) ? RK_FOUND : RK_FAILED;
               rsp_tick_in = det_tick_ff;
            end
         endcase
      end
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_low_ff   <= RPM_LOW_RESET;
         rpm_high_ff  <= RPM_HIGH_RESET;
         tick_ff      <= '0;
         det_tick_ff  <= '0;
         meas_ff      <= '0;
         closed_ff    <= 1'b0;
         flux_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rpm_low_ff   <= rpm_low_in;
         rpm_high_ff  <= rpm_high_in;
         tick_ff      <= tick_in;
         det_tick_ff  <= det_tick_in;
         meas_ff      <= meas_in;
         closed_ff    <= closed_in;
         flux_ff      <= flux_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      item_b7_ff    <= item_b7_in;
      item_carry_ff <= item_carry_in;
      item_last_ff  <= item_last_in;
      prod_lo_ff    <= prod_lo_in;
      prod_hi_ff    <= prod_hi_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_flux_ff   <= rsp_flux_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

@@ rtl/fsd_ctrl.sv @@
// Sequencer for byte intake, result emission and sample clock detection.
module fsd_ctrl
   import fsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  fsd_status_type status,
   output fsd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC,
      ST_TRACK,
      ST_MUL,
      ST_CMP,
      ST_CLOCK
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] try_ff, try_in;

   always_comb begin
      state_in = state_ff;
      try_in   = try_ff;
      cmd      = '0;
      cmd.out_sel = OUT_FLUX;
      cmd.try_sel = try_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid) begin
               if (status.req_kind) begin
                  cmd.flux_add = !status.req_b7;
                  state_in = ST_DEC;
               end else if (!status.tick_known) begin
                  cmd.meas_add = 1'b1;
                  if (status.req_last) begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         // Emit the result of the decode byte itself, unless it is a carry byte
         ST_DEC: begin
            if (status.item_b7 || !status.item_carry) begin
               if (status.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_last   = !status.item_last;
                  cmd.out_sel    = status.item_b7 ? OUT_REV : OUT_FLUX;
                  cmd.flux_clear = !status.item_b7;
                  state_in = status.item_last ? ST_TRACK : ST_IDLE;
               end
            end else begin
               state_in = status.item_last ? ST_TRACK : ST_IDLE;
            end
         end
         // Drop any carried count and mark the track end
         ST_TRACK: begin
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_sel    = OUT_TRACK;
               cmd.flux_clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            try_in  = '0;
            state_in = ST_CMP;
         end
         // Advance through the candidate clocks until one fits or the last has been tried
         ST_CMP: begin
            if (status.try_hit || try_ff == TRY_LAST) begin
               cmd.det_set = 1'b1;
               state_in = ST_CLOCK;
            end else begin
               try_in = try_ff + 2'd1;
            end
         end
         ST_CLOCK: begin
            if (status.out_free) begin
               cmd.out_load    = 1'b1;
               cmd.out_last    = 1'b1;
               cmd.out_sel     = OUT_CLOCK;
               cmd.meas_finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         try_ff   <= '0;
      end else begin
         state_ff <= state_in;
         try_ff   <= try_in;
      end
   end

endmodule

@@ rtl/flux_stream_decoder_clock_detect_core.sv @@
// Decode pass byte: taken in idle, result loaded from the decode state, plus the track state at
// track end; no new byte is taken before the last is through. Measure pass byte: taken in idle;
// with no tick known, the track's last byte runs the detect sequence (multiply, the clock
// compares in the shared comparator, result load). Output waits in a result register, and a
// stalled result holds the sequencer in its emit state. Reset (synchronous, active high) clears
// tick period, both counts and limits to 285/380 rpm. No clearing pass is needed after reset.
module flux_stream_decoder_clock_detect_core
   import fsd_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   fsd_req_if.sink   req_bus,
   fsd_rsp_if.source rsp_bus,
   fsd_csr_if.sink   csr_bus
);

   fsd_cmd_type    cmd;
   fsd_status_type status;

   fsd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   fsd_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .status  (status)
   );

endmodule
